>>> src/cchit_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the capsule-capsule hit test pipeline.
package cchit_pkg;

    // Input field widths
    localparam int FIELD_W = 32;
    localparam int RAD_W   = 31;
    localparam int RSUM_W  = RAD_W + 1;

    // Coordinate difference and dot-product widths
    localparam int DIFF_W  = FIELD_W + 1;
    localparam int DOT_W   = 2 * DIFF_W + 2;

    // Axes per point
    localparam int NAX     = 3;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

endpackage

>>> src/capsule_capsule_hit_test_top.sv
`timescale 1ns / 1ps
// Capsule-capsule hit test: closest points of two segments, fully pipelined.
//
//  channel   direction  handshake          payload
//  input     in         i_valid / o_stall  i_op, i_top_*, i_bottom_*, i_radius
//  output    out        o_valid / i_stall  o_hit
//
// One item is taken per cycle while o_stall is low. A test item passes the dot
// products and then the two chained divider pipelines for s and t, one quotient
// bit per stage, before its result leaves.
// A load item updates the reference at once and produces no result.
// Reset clears the reference capsule and all valid bits.
// While a result waits under stall, the whole pipeline holds.
module capsule_capsule_hit_test_top #(
    parameter int COORD_WIDTH         = 32,
    parameter int PARAM_FRACTION_BITS = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_op,
    input  logic signed [cchit_pkg::FIELD_W-1:0] i_top_x,
    input  logic signed [cchit_pkg::FIELD_W-1:0] i_top_y,
    input  logic signed [cchit_pkg::FIELD_W-1:0] i_top_z,
    input  logic signed [cchit_pkg::FIELD_W-1:0] i_bottom_x,
    input  logic signed [cchit_pkg::FIELD_W-1:0] i_bottom_y,
    input  logic signed [cchit_pkg::FIELD_W-1:0] i_bottom_z,
    input  logic [cchit_pkg::RAD_W-1:0]         i_radius,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_hit
);
    import cchit_pkg::*;

    localparam int F    = PARAM_FRACTION_BITS;
    localparam int CV   = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;
    localparam int QW   = F + 1;
    localparam int SBW  = F + 2;
    localparam int PRW  = 2 * DOT_W;
    localparam int NUMW = PRW + 1;
    localparam int WS   = NUMW - 1 + F;
    localparam int WA   = DOT_W - 1 + F;
    localparam int NT   = DOT_W + F + 3;
    localparam int WT   = DOT_W + F;
    localparam int KW   = DIFF_W + F + 3;
    localparam int SW   = 2 * KW + 2;
    localparam int SD   = 9 + F;
    localparam int TD   = SD + 5 + F;
    localparam int LAST = TD + 9;
    localparam int LAT  = LAST + 1;
    localparam logic [F:0] FONE = {1'b1, {F{1'b0}}};

    typedef struct packed {
        logic       ovr;
        logic [F:0] q;
    } t_fctl;

    // Sign-extend the live coordinate bits
    function automatic logic signed [DIFF_W-1:0] f_coord(input logic [FIELD_W-1:0] x);
        return DIFF_W'(signed'(x[CV-1:0]));
    endfunction

    // Decide a clamped quotient that needs no division
    function automatic t_fctl f_frac_ctl(input logic signed [DOT_W:0] num,
                                         input logic signed [DOT_W:0] den);
        t_fctl c;
        logic  pos;
        pos   = !num[DOT_W] && (num != '0);
        c.ovr = !pos || (num >= den);
        c.q   = pos ? FONE : '0;
        return c;
    endfunction

    logic en;
    logic [LAT-1:0] r_vld;

    logic [FIELD_W-1:0] w_top [NAX];
    logic [FIELD_W-1:0] w_bot [NAX];
    logic [FIELD_W-1:0] r_ref_top [NAX];
    logic [FIELD_W-1:0] r_ref_bot [NAX];
    logic [RAD_W-1:0]   r_ref_rad;

    assign w_top[0] = i_top_x;
    assign w_top[1] = i_top_y;
    assign w_top[2] = i_top_z;
    assign w_bot[0] = i_bottom_x;
    assign w_bot[1] = i_bottom_y;
    assign w_bot[2] = i_bottom_z;

    // Hold everything while a result waits under stall
    assign en      = !(r_vld[LAST] && i_stall);
    assign o_stall = r_vld[LAST] && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid && (i_op == OP_TEST)};
        end
    end

    // Store the reference capsule on a load item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NAX; k++) begin
                r_ref_top[k] <= '0;
                r_ref_bot[k] <= '0;
            end
            r_ref_rad <= '0;
        end else if (en && i_valid && (i_op == OP_LOAD)) begin
            for (int k = 0; k < NAX; k++) begin
                r_ref_top[k] <= w_top[k];
                r_ref_bot[k] <= w_bot[k];
            end
            r_ref_rad <= i_radius;
        end
    end

    // Stage 0: directions, offset and radius sum
    logic signed [DIFF_W-1:0] r_d1 [NAX];
    logic signed [DIFF_W-1:0] r_d2 [NAX];
    logic signed [DIFF_W-1:0] r_rr [NAX];
    logic [RSUM_W-1:0]        r_rsum;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < NAX; k++) begin
                r_d1[k] <= f_coord(r_ref_bot[k]) - f_coord(r_ref_top[k]);
                r_d2[k] <= f_coord(w_bot[k]) - f_coord(w_top[k]);
                r_rr[k] <= f_coord(r_ref_top[k]) - f_coord(w_top[k]);
            end
            r_rsum <= RSUM_W'(r_ref_rad) + RSUM_W'(i_radius);
        end
    end

    // Stages 1-3: per-axis dot product terms
    logic signed [2*DIFF_W-1:0] w_paa [NAX];
    logic signed [2*DIFF_W-1:0] w_pab [NAX];
    logic signed [2*DIFF_W-1:0] w_pac [NAX];
    logic signed [2*DIFF_W-1:0] w_pae [NAX];
    logic signed [2*DIFF_W-1:0] w_paf [NAX];

    for (genvar k = 0; k < NAX; k++) begin : g_dot
        cchit_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_aa (
            .i_clk(i_clk), .i_en(en), .i_a(r_d1[k]), .i_b(r_d1[k]), .o_p(w_paa[k]));
        cchit_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_ab (
            .i_clk(i_clk), .i_en(en), .i_a(r_d1[k]), .i_b(r_d2[k]), .o_p(w_pab[k]));
        cchit_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_ac (
            .i_clk(i_clk), .i_en(en), .i_a(r_d1[k]), .i_b(r_rr[k]), .o_p(w_pac[k]));
        cchit_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_ae (
            .i_clk(i_clk), .i_en(en), .i_a(r_d2[k]), .i_b(r_d2[k]), .o_p(w_pae[k]));
        cchit_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_af (
            .i_clk(i_clk), .i_en(en), .i_a(r_d2[k]), .i_b(r_rr[k]), .o_p(w_paf[k]));
    end

    // Stage 4: sum the dot products
    logic signed [DOT_W-1:0] r_a, r_b, r_c, r_e, r_f;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a <= DOT_W'(w_paa[0]) + DOT_W'(w_paa[1]) + DOT_W'(w_paa[2]);
            r_b <= DOT_W'(w_pab[0]) + DOT_W'(w_pab[1]) + DOT_W'(w_pab[2]);
            r_c <= DOT_W'(w_pac[0]) + DOT_W'(w_pac[1]) + DOT_W'(w_pac[2]);
            r_e <= DOT_W'(w_pae[0]) + DOT_W'(w_pae[1]) + DOT_W'(w_pae[2]);
            r_f <= DOT_W'(w_paf[0]) + DOT_W'(w_paf[1]) + DOT_W'(w_paf[2]);
        end
    end

    // Stages 5-7: cross products for the line solution
    logic signed [PRW-1:0] w_ae, w_bb, w_bf, w_ce;

    cchit_mul #(.AW(DOT_W), .BW(DOT_W)) u_mae (
        .i_clk(i_clk), .i_en(en), .i_a(r_a), .i_b(r_e), .o_p(w_ae));
    cchit_mul #(.AW(DOT_W), .BW(DOT_W)) u_mbb (
        .i_clk(i_clk), .i_en(en), .i_a(r_b), .i_b(r_b), .o_p(w_bb));
    cchit_mul #(.AW(DOT_W), .BW(DOT_W)) u_mbf (
        .i_clk(i_clk), .i_en(en), .i_a(r_b), .i_b(r_f), .o_p(w_bf));
    cchit_mul #(.AW(DOT_W), .BW(DOT_W)) u_mce (
        .i_clk(i_clk), .i_en(en), .i_a(r_c), .i_b(r_e), .o_p(w_ce));

    logic [5*DOT_W-1:0] w_p8;
    logic signed [DOT_W-1:0] w_a8, w_b8, w_c8, w_e8, w_f8;

    cchit_dly #(.W(5*DOT_W), .N(4)) u_dly8 (
        .i_clk(i_clk), .i_en(en), .i_d({r_a, r_b, r_c, r_e, r_f}), .o_d(w_p8));

    assign w_a8 = signed'(w_p8[4*DOT_W +: DOT_W]);
    assign w_b8 = signed'(w_p8[3*DOT_W +: DOT_W]);
    assign w_c8 = signed'(w_p8[2*DOT_W +: DOT_W]);
    assign w_e8 = signed'(w_p8[DOT_W +: DOT_W]);
    assign w_f8 = signed'(w_p8[0 +: DOT_W]);

    // Stage 8: denominator and numerator of s
    logic signed [NUMW-1:0] r_den, r_num;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_den <= NUMW'(w_ae) - NUMW'(w_bb);
            r_num <= NUMW'(w_bf) - NUMW'(w_ce);
        end
    end

    // Set up the four parallel dividers
    logic  w_den_pos, w_num_pos, w_s_ge, w_s_ovr;
    logic [F:0] w_s_ovq;
    logic signed [DOT_W:0] w_nlo, w_nhi, w_nt0, w_da, w_de;
    t_fctl w_clo, w_chi, w_ct0;
    logic [F:0] w_smain, w_slo, w_shi, w_t0;

    assign w_den_pos = !r_den[NUMW-1] && (r_den != '0);
    assign w_num_pos = !r_num[NUMW-1] && (r_num != '0);
    assign w_s_ge    = r_num >= r_den;
    assign w_s_ovr   = !w_den_pos || !w_num_pos || w_s_ge;
    assign w_s_ovq   = (w_den_pos && w_num_pos) ? FONE : '0;

    assign w_nlo = -(DOT_W+1)'(w_c8);
    assign w_nhi = (DOT_W+1)'(w_b8) - (DOT_W+1)'(w_c8);
    assign w_nt0 = (DOT_W+1)'(w_f8);
    assign w_da  = (DOT_W+1)'(w_a8);
    assign w_de  = (DOT_W+1)'(w_e8);
    assign w_clo = f_frac_ctl(w_nlo, w_da);
    assign w_chi = f_frac_ctl(w_nhi, w_da);
    assign w_ct0 = f_frac_ctl(w_nt0, w_de);

    cchit_div #(.W(WS), .F(F)) u_div_s (
        .i_clk(i_clk), .i_en(en),
        .i_n({r_num[NUMW-2:0], {F{1'b0}}}), .i_d(WS'(r_den[NUMW-2:0])),
        .i_ovr(w_s_ovr), .i_ovr_q(w_s_ovq), .o_q(w_smain));
    cchit_div #(.W(WA), .F(F)) u_div_lo (
        .i_clk(i_clk), .i_en(en),
        .i_n({w_nlo[DOT_W-2:0], {F{1'b0}}}), .i_d(WA'(w_a8[DOT_W-2:0])),
        .i_ovr(w_clo.ovr), .i_ovr_q(w_clo.q), .o_q(w_slo));
    cchit_div #(.W(WA), .F(F)) u_div_hi (
        .i_clk(i_clk), .i_en(en),
        .i_n({w_nhi[DOT_W-2:0], {F{1'b0}}}), .i_d(WA'(w_a8[DOT_W-2:0])),
        .i_ovr(w_chi.ovr), .i_ovr_q(w_chi.q), .o_q(w_shi));
    cchit_div #(.W(WA), .F(F)) u_div_t0 (
        .i_clk(i_clk), .i_en(en),
        .i_n({w_nt0[DOT_W-2:0], {F{1'b0}}}), .i_d(WA'(w_e8[DOT_W-2:0])),
        .i_ovr(w_ct0.ovr), .i_ovr_q(w_ct0.q), .o_q(w_t0));

    // Carry b, e, f and the point flags across the dividers
    logic [3*DOT_W+1:0] w_psd;
    logic signed [DOT_W-1:0] w_bsd, w_esd, w_fsd;
    logic w_azsd, w_ezsd;

    cchit_dly #(.W(3*DOT_W+2), .N(F+1)) u_dlysd (
        .i_clk(i_clk), .i_en(en),
        .i_d({w_b8, w_e8, w_f8, (w_a8 == '0), (w_e8 == '0)}), .o_d(w_psd));

    assign w_bsd  = signed'(w_psd[2*DOT_W+2 +: DOT_W]);
    assign w_esd  = signed'(w_psd[DOT_W+2 +: DOT_W]);
    assign w_fsd  = signed'(w_psd[2 +: DOT_W]);
    assign w_azsd = w_psd[1];
    assign w_ezsd = w_psd[0];

    // Numerator of t: b*s + f
    logic signed [DOT_W+SBW-1:0] w_bs;

    cchit_mul #(.AW(DOT_W), .BW(SBW)) u_mbs (
        .i_clk(i_clk), .i_en(en), .i_a(w_bsd), .i_b(signed'({1'b0, w_smain})), .o_p(w_bs));

    localparam int P3W = 2 * DOT_W + 2 + 4 * QW;
    logic [P3W-1:0] w_p3;
    logic signed [DOT_W-1:0] w_e3, w_f3;
    logic w_az3, w_ez3;
    logic [F:0] w_sm3, w_slo3, w_shi3, w_t03;

    cchit_dly #(.W(P3W), .N(3)) u_dly3 (
        .i_clk(i_clk), .i_en(en),
        .i_d({w_esd, w_fsd, w_azsd, w_ezsd, w_smain, w_slo, w_shi, w_t0}), .o_d(w_p3));

    assign w_e3   = signed'(w_p3[DOT_W+2+4*QW +: DOT_W]);
    assign w_f3   = signed'(w_p3[2+4*QW +: DOT_W]);
    assign w_az3  = w_p3[1+4*QW];
    assign w_ez3  = w_p3[4*QW];
    assign w_sm3  = w_p3[3*QW +: QW];
    assign w_slo3 = w_p3[2*QW +: QW];
    assign w_shi3 = w_p3[QW +: QW];
    assign w_t03  = w_p3[0 +: QW];

    logic signed [NT-1:0] w_nt;
    logic w_nt_neg, w_nt_gt;
    logic n_tovr;
    logic [F:0] n_tq, n_ssel;
    logic [WT-1:0] r_tn, r_te;
    logic r_tovr;
    logic [F:0] r_tq, r_ssel;

    assign w_nt     = NT'(w_bs) + (NT'(w_f3) <<< F);
    assign w_nt_neg = w_nt[NT-1];
    assign w_nt_gt  = w_nt > (NT'(w_e3) <<< F);

    // Pick s and decide whether t needs a division
    always_comb begin
        n_tovr = 1'b1;
        n_tq   = '0;
        n_ssel = w_sm3;
        priority if (w_az3 && w_ez3) begin
            n_ssel = '0;
        end else if (w_az3) begin
            n_ssel = '0;
            n_tq   = w_t03;
        end else if (w_ez3) begin
            n_ssel = w_slo3;
        end else if (w_nt_neg) begin
            n_ssel = w_slo3;
        end else if (w_nt_gt) begin
            n_ssel = w_shi3;
            n_tq   = FONE;
        end else begin
            n_tovr = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tn   <= w_nt[WT-1:0];
            r_te   <= WT'($unsigned(w_e3));
            r_tovr <= n_tovr;
            r_tq   <= n_tq;
            r_ssel <= n_ssel;
        end
    end

    logic [F:0] w_tfin, w_sfin;

    cchit_div #(.W(WT), .F(F)) u_div_t (
        .i_clk(i_clk), .i_en(en), .i_n(r_tn), .i_d(r_te),
        .i_ovr(r_tovr), .i_ovr_q(r_tq), .o_q(w_tfin));

    cchit_dly #(.W(QW), .N(F+1)) u_dlys (
        .i_clk(i_clk), .i_en(en), .i_d(r_ssel), .o_d(w_sfin));

    // Align directions, offset and squared radius sum with s and t
    logic [2*NAX*DIFF_W-1:0] w_dtd;
    logic [NAX*DIFF_W-1:0]   w_rtd;
    logic signed [2*DIFF_W-1:0] w_rsq, w_rsq8;
    logic [2*DIFF_W-1:0] w_rsq8u;

    cchit_dly #(.W(2*NAX*DIFF_W), .N(TD)) u_dlyd (
        .i_clk(i_clk), .i_en(en),
        .i_d({r_d1[2], r_d1[1], r_d1[0], r_d2[2], r_d2[1], r_d2[0]}), .o_d(w_dtd));
    cchit_dly #(.W(NAX*DIFF_W), .N(TD+3)) u_dlyr (
        .i_clk(i_clk), .i_en(en), .i_d({r_rr[2], r_rr[1], r_rr[0]}), .o_d(w_rtd));

    cchit_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_mrsq (
        .i_clk(i_clk), .i_en(en),
        .i_a(signed'({1'b0, r_rsum})), .i_b(signed'({1'b0, r_rsum})), .o_p(w_rsq));
    cchit_dly #(.W(2*DIFF_W), .N(TD+5)) u_dlyrsq (
        .i_clk(i_clk), .i_en(en), .i_d(w_rsq), .o_d(w_rsq8u));

    assign w_rsq8 = signed'(w_rsq8u);

    // Closest-point difference per axis, then its square
    logic signed [DIFF_W+SBW-1:0] w_d1s [NAX];
    logic signed [DIFF_W+SBW-1:0] w_d2t [NAX];
    logic signed [KW-1:0]         r_dk  [NAX];
    logic signed [2*KW-1:0]       w_dk2 [NAX];

    for (genvar k = 0; k < NAX; k++) begin : g_dist
        cchit_mul #(.AW(DIFF_W), .BW(SBW)) u_d1s (
            .i_clk(i_clk), .i_en(en),
            .i_a(signed'(w_dtd[(NAX+k)*DIFF_W +: DIFF_W])),
            .i_b(signed'({1'b0, w_sfin})), .o_p(w_d1s[k]));
        cchit_mul #(.AW(DIFF_W), .BW(SBW)) u_d2t (
            .i_clk(i_clk), .i_en(en),
            .i_a(signed'(w_dtd[k*DIFF_W +: DIFF_W])),
            .i_b(signed'({1'b0, w_tfin})), .o_p(w_d2t[k]));

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dk[k] <= (KW'(signed'(w_rtd[k*DIFF_W +: DIFF_W])) <<< F)
                         + KW'(w_d1s[k]) - KW'(w_d2t[k]);
            end
        end

        cchit_mul #(.AW(KW), .BW(KW)) u_dk2 (
            .i_clk(i_clk), .i_en(en), .i_a(r_dk[k]), .i_b(r_dk[k]), .o_p(w_dk2[k]));
    end

    // Sum the squares and compare against the radius sum squared
    logic signed [SW-1:0] r_sum;
    logic r_hit;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum <= SW'(w_dk2[0]) + SW'(w_dk2[1]) + SW'(w_dk2[2]);
            r_hit <= r_sum <= (SW'(w_rsq8) <<< (2 * F));
        end
    end

    assign o_valid = r_vld[LAST];
    assign o_hit   = r_hit;

endmodule

>>> src/cchit_mul.sv
`timescale 1ns / 1ps
// Three-stage signed multiplier built from four half-width partial products.
module cchit_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [AW-1:0]    i_a,
    input  logic signed [BW-1:0]    i_b,
    output logic signed [AW+BW-1:0] o_p
);
    localparam int PW = AW + BW;
    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;

    logic [AW-1:0]       n_ma, r_ma;
    logic [BW-1:0]       n_mb, r_mb;
    logic                r_neg1, r_neg2;
    logic [AL+BL-1:0]    r_ll;
    logic [AL+BH-1:0]    r_lh;
    logic [AH+BL-1:0]    r_hl;
    logic [AH+BH-1:0]    r_hh;
    logic [PW-1:0]       n_mag;
    logic signed [PW-1:0] r_p;

    // Take magnitudes
    assign n_ma = i_a[AW-1] ? (~i_a + 1'b1) : i_a;
    assign n_mb = i_b[BW-1] ? (~i_b + 1'b1) : i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ma   <= n_ma;
            r_mb   <= n_mb;
            r_neg1 <= i_a[AW-1] ^ i_b[BW-1];
        end
    end

    // Form partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll   <= r_ma[AL-1:0] * r_mb[BL-1:0];
            r_lh   <= r_ma[AL-1:0] * r_mb[BW-1:BL];
            r_hl   <= r_ma[AW-1:AL] * r_mb[BL-1:0];
            r_hh   <= r_ma[AW-1:AL] * r_mb[BW-1:BL];
            r_neg2 <= r_neg1;
        end
    end

    // Add partial products and restore the sign
    assign n_mag = (PW'(r_hh) << (AL + BL)) + (PW'(r_hl) << AL)
                 + (PW'(r_lh) << BL) + PW'(r_ll);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_neg2 ? signed'(-n_mag) : signed'(n_mag);
        end
    end

    assign o_p = r_p;

endmodule

>>> src/cchit_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, with a forced-result bypass.
module cchit_div #(
    parameter int W = 92,
    parameter int F = 24
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_n,
    input  logic [W-1:0] i_d,
    input  logic         i_ovr,
    input  logic [F:0]   i_ovr_q,
    output logic [F:0]   o_q
);
    logic [W-1:0] r_rem [F];
    logic [W-1:0] r_den [F];
    logic         r_ovr [F];
    logic [F:0]   r_q   [F+1];

    for (genvar j = 0; j <= F; j++) begin : g_st
        logic [W-1:0] w_rem;
        logic [W-1:0] w_den;
        logic [F:0]   w_qi;
        logic         w_ovi;
        logic [W+F:0] w_dsh;
        logic         w_ge;

        if (j == 0) begin : g_first
            assign w_rem = i_n;
            assign w_den = i_d;
            assign w_qi  = i_ovr ? i_ovr_q : '0;
            assign w_ovi = i_ovr;
        end else begin : g_next
            assign w_rem = r_rem[j-1];
            assign w_den = r_den[j-1];
            assign w_qi  = r_q[j-1];
            assign w_ovi = r_ovr[j-1];
        end

        // Compare against the divisor scaled to this bit
        assign w_dsh = (W+F+1)'(w_den) << (F - j);
        assign w_ge  = ((W+F+1)'(w_rem) >= w_dsh) && !w_ovi;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[j] <= w_qi | ((F+1)'(w_ge) << (F - j));
            end
        end

        // Carry the remainder to the next bit
        if (j < F) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[j] <= w_ge ? (w_rem - w_dsh[W-1:0]) : w_rem;
                    r_den[j] <= w_den;
                    r_ovr[j] <= w_ovi;
                end
            end
        end
    end

    assign o_q = r_q[F];

endmodule

>>> src/cchit_dly.sv
`timescale 1ns / 1ps
// Enabled shift-register delay line that keeps side data aligned with the pipeline.
module cchit_dly #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_d
);
    logic [W-1:0] r_tap [N];

    // Advance all taps together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int i = 1; i < N; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_d = r_tap[N-1];

endmodule
